// ----- rtl/sphere_box_hit_face_macros.svh -----
// Assertion macros for the sphere/box hit pipeline.
// Expects clk_i and rst_ni in the scope where they are used.
`ifndef SPHERE_BOX_HIT_FACE_MACROS_SVH
`define SPHERE_BOX_HIT_FACE_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define SBHF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen out of reset.
`define SBHF_NEVER(label, cond, msg) \
  `SBHF_ASSERT(label, !(cond), msg)

`endif

// ----- rtl/sbhf_pkg.sv -----
// Shared types for the sphere/box hit pipeline: struck-face codes.
// No dependencies.
`default_nettype none

package sbhf_pkg;

  localparam int unsigned FaceW = 3;

  typedef enum logic [FaceW-1:0] {
    FACE_NONE  = 3'd0,
    FACE_LEFT  = 3'd1,
    FACE_RIGHT = 3'd2,
    FACE_UP    = 3'd3,
    FACE_DOWN  = 3'd4,
    FACE_FRONT = 3'd5,
    FACE_BACK  = 3'd6
  } face_e;

endpackage

`default_nettype wire

// ----- rtl/sbhf_if.sv -----
// Valid/ready channel interfaces for query items and hit results.
// Depends on sbhf_pkg for the face field width.
`default_nettype none

interface sbhf_in_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] sphere_x;
  logic signed [COORD_BITS-1:0] sphere_y;
  logic signed [COORD_BITS-1:0] sphere_z;
  logic        [COORD_BITS-2:0] sphere_radius;
  logic signed [COORD_BITS-1:0] box_x;
  logic signed [COORD_BITS-1:0] box_y;
  logic signed [COORD_BITS-1:0] box_z;
  logic        [COORD_BITS-2:0] extent_x;
  logic        [COORD_BITS-2:0] extent_y;
  logic        [COORD_BITS-2:0] extent_z;

  modport source (
    output valid, sphere_x, sphere_y, sphere_z, sphere_radius,
           box_x, box_y, box_z, extent_x, extent_y, extent_z,
    input  ready
  );
  modport sink (
    input  valid, sphere_x, sphere_y, sphere_z, sphere_radius,
           box_x, box_y, box_z, extent_x, extent_y, extent_z,
    output ready
  );
endinterface

interface sbhf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [sbhf_pkg::FaceW-1:0]    hit_face;

  modport source (output valid, hit, hit_face, input ready);
  modport sink   (input valid, hit, hit_face, output ready);
endinterface

`default_nettype wire

// ----- rtl/sphere_box_hit_face.sv -----
// Sphere against axis-aligned box test with struck-face report, four stages.
// Depends on sbhf_pkg, sbhf_if.sv and sphere_box_hit_face_macros.svh.
//
//   channel | dir | handshake     | payload
//   in_i    | in  | valid/ready   | sphere centre, radius, box centre, full sizes
//   out_o   | out | valid/ready   | hit, hit_face
//
// One item per cycle sustained while the output is taken; each result is offered
// once it has passed four register stages (bounds, outside distance and face,
// squares, sum and compare), the first loading on the transfer edge.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up and a stalled output holds the whole line without loss.
// Reset clears the stage valid bits only; the data registers are not reset.
`default_nettype none
`include "sphere_box_hit_face_macros.svh"

module sphere_box_hit_face
  import sbhf_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  sbhf_in_if.sink     in_i,
  sbhf_out_if.source  out_o
);

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned SqW = 2 * W - 2;

  // Stage enables, back to front.
  logic vo_q, v3_q, v2_q, v1_q;
  logic en_o, en3, en2, en1;

  assign en_o = !vo_q || out_o.ready;
  assign en3  = !v3_q || en_o;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;

  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1)  v1_q <= in_i.valid;
      if (en2)  v2_q <= v1_q;
      if (en3)  v3_q <= v2_q;
      if (en_o) vo_q <= v3_q;
    end
  end

  // ---------------- stage 1: bounds and box-minus-sphere vector
  logic signed [W-1:0] s_c [3];
  logic signed [W-1:0] b_c [3];
  logic        [W-3:0] h_c [3];

  assign s_c[0] = in_i.sphere_x;
  assign s_c[1] = in_i.sphere_y;
  assign s_c[2] = in_i.sphere_z;
  assign b_c[0] = in_i.box_x;
  assign b_c[1] = in_i.box_y;
  assign b_c[2] = in_i.box_z;
  assign h_c[0] = in_i.extent_x[W-2:1];
  assign h_c[1] = in_i.extent_y[W-2:1];
  assign h_c[2] = in_i.extent_z[W-2:1];

  logic signed [W-1:0] c1_q   [3];
  logic signed [W:0]   lo1_d  [3];
  logic signed [W:0]   hi1_d  [3];
  logic signed [W:0]   vec1_d [3];
  logic signed [W:0]   lo1_q  [3];
  logic signed [W:0]   hi1_q  [3];
  logic signed [W:0]   vec1_q [3];
  logic        [W-2:0] r1_q;
  logic        [W-3:0] hx1_q, hz1_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo1_d[k]  = $signed({b_c[k][W-1], b_c[k]}) - $signed({3'b000, h_c[k]});
      hi1_d[k]  = $signed({b_c[k][W-1], b_c[k]}) + $signed({3'b000, h_c[k]});
      vec1_d[k] = $signed({b_c[k][W-1], b_c[k]}) - $signed({s_c[k][W-1], s_c[k]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int k = 0; k < 3; k++) begin
        c1_q[k]   <= s_c[k];
        lo1_q[k]  <= lo1_d[k];
        hi1_q[k]  <= hi1_d[k];
        vec1_q[k] <= vec1_d[k];
      end
      r1_q  <= in_i.sphere_radius;
      hx1_q <= h_c[0];
      hz1_q <= h_c[2];
    end
  end

  // ---------------- stage 2: outside distance per axis, face class
  logic signed [W+1:0] ce2   [3];
  logic signed [W+1:0] loe2  [3];
  logic signed [W+1:0] hie2  [3];
  logic signed [W+1:0] dlo2  [3];
  logic signed [W+1:0] dhi2  [3];
  logic        [W:0]   d2    [3];
  logic        [W:0]   mag2  [3];
  logic        [W-2:0] dist2_d [3];
  logic                far2_d;
  logic        [W:0]   hxe2, hze2;
  logic                use_x, use_zx, use_zy;
  face_e               face2_d;

  always_comb begin
    far2_d = 1'b0;
    for (int k = 0; k < 3; k++) begin
      ce2[k]  = {{2{c1_q[k][W-1]}}, c1_q[k]};
      loe2[k] = {lo1_q[k][W], lo1_q[k]};
      hie2[k] = {hi1_q[k][W], hi1_q[k]};
      dlo2[k] = loe2[k] - ce2[k];
      dhi2[k] = ce2[k] - hie2[k];
      if (ce2[k] < loe2[k]) begin
        d2[k] = dlo2[k][W:0];
      end else if (ce2[k] > hie2[k]) begin
        d2[k] = dhi2[k][W:0];
      end else begin
        d2[k] = '0;
      end
      // A distance at or above the radius forces a miss on its own.
      if (d2[k] >= {2'b00, r1_q}) far2_d = 1'b1;
      dist2_d[k] = d2[k][W-2:0];
      mag2[k] = vec1_q[k][W] ? $unsigned(-vec1_q[k]) : $unsigned(vec1_q[k]);
    end

    hxe2   = {3'b000, hx1_q};
    hze2   = {3'b000, hz1_q};
    use_x  = (mag2[0] > mag2[1]) && (mag2[0] > hxe2);
    use_zx = (mag2[2] > mag2[0]) && (mag2[2] > hze2);
    use_zy = (mag2[2] > mag2[1]) && (mag2[2] > hze2);

    if (use_x ? use_zx : use_zy) begin
      face2_d = vec1_q[2][W] ? FACE_BACK : FACE_FRONT;
    end else if (use_x) begin
      face2_d = vec1_q[0][W] ? FACE_RIGHT : FACE_LEFT;
    end else begin
      face2_d = vec1_q[1][W] ? FACE_UP : FACE_DOWN;
    end
  end

  logic [W-2:0] dist2_q [3];
  logic [W-2:0] r2_q;
  logic         far2_q;
  face_e        face2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int k = 0; k < 3; k++) dist2_q[k] <= dist2_d[k];
      r2_q    <= r1_q;
      far2_q  <= far2_d;
      face2_q <= face2_d;
    end
  end

  // ---------------- stage 3: squares
  logic [SqW-1:0] sq3_q [3];
  logic [SqW-1:0] rr3_q;
  logic           far3_q;
  face_e          face3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int k = 0; k < 3; k++) sq3_q[k] <= SqW'(dist2_q[k]) * SqW'(dist2_q[k]);
      rr3_q   <= SqW'(r2_q) * SqW'(r2_q);
      far3_q  <= far2_q;
      face3_q <= face2_q;
    end
  end

  // ---------------- stage 4: sum, compare, output register
  logic [2*W-1:0] sum4;
  logic           hit4;
  logic           hit_q;
  face_e          face_q;

  assign sum4 = {2'b00, sq3_q[0]} + {2'b00, sq3_q[1]} + {2'b00, sq3_q[2]};
  assign hit4 = !far3_q && (sum4 < {2'b00, rr3_q});

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      hit_q  <= hit4;
      face_q <= hit4 ? face3_q : FACE_NONE;
    end
  end

  assign out_o.valid    = vo_q;
  assign out_o.hit      = hit_q;
  assign out_o.hit_face = face_q;

  // ---------------- checks
  `SBHF_NEVER(a_hit_has_face, vo_q && hit_q && (face_q == FACE_NONE),
              "hit reported with no face")
  `SBHF_NEVER(a_miss_no_face, vo_q && !hit_q && (face_q != FACE_NONE),
              "miss reported with a face")
  `SBHF_ASSERT(a_stall_source, !en1 |-> (vo_q && !out_o.ready),
               "input held off without an output stall")
  `SBHF_ASSERT(a_advance, (v3_q && en_o) |=> vo_q,
               "item lost between last stage and output")

endmodule

`default_nettype wire

// ----- tb/tb_sphere_box_hit_face.sv -----
// Testbench for sphere_box_hit_face: drives sphere/box queries over the input channel
// and checks every hit/face result against a local predictor.
// Depends on sbhf_pkg, sbhf_if.sv and the sphere_box_hit_face RTL.
`timescale 1ns / 1ps

module tb_sphere_box_hit_face;
  import sbhf_pkg::*;

  localparam int unsigned COORD_BITS = 16;
  localparam int STALL_LEN      = 64;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] sz;
    logic        [COORD_BITS-2:0] radius;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] bz;
    logic        [COORD_BITS-2:0] ex;
    logic        [COORD_BITS-2:0] ey;
    logic        [COORD_BITS-2:0] ez;
  } sphere_box_t;

  typedef struct {
    logic  hit;
    face_e face;
  } contact_t;

  typedef enum int {AXIS_X, AXIS_Y, AXIS_Z} axis_e;

  logic clk_i;
  logic rst_ni;

  sbhf_in_if #(.COORD_BITS(COORD_BITS)) in_if ();
  sbhf_out_if out_if ();

  sphere_box_hit_face #(.COORD_BITS(COORD_BITS)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  contact_t pending_contacts[$];
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       stall_requests = 0;
  int       stall_served = 0;
  int       stall_left = 0;
  int       quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Expected hit and struck face for one query; all sums are exact in 64 bits.
  function automatic contact_t classify_contact(sphere_box_t q);
    longint   sc[3];
    longint   bc[3];
    longint   half[3];
    longint   lo, hi, d, r, sum, vx, vy, vz, ax, ay, az;
    bit       miss;
    axis_e    axis;
    contact_t res;
    sc[0] = longint'(q.sx);  sc[1] = longint'(q.sy);  sc[2] = longint'(q.sz);
    bc[0] = longint'(q.bx);  bc[1] = longint'(q.by);  bc[2] = longint'(q.bz);
    half[0] = longint'(q.ex >> 1);
    half[1] = longint'(q.ey >> 1);
    half[2] = longint'(q.ez >> 1);
    r    = longint'(q.radius);
    sum  = 0;
    miss = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lo = bc[i] - half[i];
      hi = bc[i] + half[i];
      d  = (sc[i] < lo) ? lo - sc[i] : (sc[i] > hi) ? sc[i] - hi : 0;
      // One axis at or beyond the radius settles a miss without the sum
      if (d >= r) miss = 1'b1;
      else sum += d * d;
    end
    if (!miss && sum >= r * r) miss = 1'b1;
    res.hit  = !miss;
    res.face = FACE_NONE;
    if (miss) return res;

    vx = bc[0] - sc[0];
    vy = bc[1] - sc[1];
    vz = bc[2] - sc[2];
    ax = (vx < 0) ? -vx : vx;
    ay = (vy < 0) ? -vy : vy;
    az = (vz < 0) ? -vz : vz;
    // Half size on y plays no part in the choice of axis
    if (ax > ay && ax > half[0]) axis = (az > ax && az > half[2]) ? AXIS_Z : AXIS_X;
    else axis = (az > ay && az > half[2]) ? AXIS_Z : AXIS_Y;
    case (axis)
      AXIS_X:  res.face = (vx >= 0) ? FACE_LEFT : FACE_RIGHT;
      AXIS_Y:  res.face = (vy >= 0) ? FACE_DOWN : FACE_UP;
      default: res.face = (vz >= 0) ? FACE_FRONT : FACE_BACK;
    endcase
    return res;
  endfunction

  function automatic sphere_box_t make_query(int sx, int sy, int sz, int r,
                                             int bx, int by, int bz,
                                             int ex, int ey, int ez);
    sphere_box_t q;
    q.sx = COORD_BITS'(sx);  q.sy = COORD_BITS'(sy);  q.sz = COORD_BITS'(sz);
    q.radius = (COORD_BITS-1)'(r);
    q.bx = COORD_BITS'(bx);  q.by = COORD_BITS'(by);  q.bz = COORD_BITS'(bz);
    q.ex = (COORD_BITS-1)'(ex);
    q.ey = (COORD_BITS-1)'(ey);
    q.ez = (COORD_BITS-1)'(ez);
    return q;
  endfunction

  // Mostly small sizes, now and then anything up to full range
  function automatic int pick_size();
    case ($urandom_range(3))
      0:       return int'($urandom_range(32767));
      1:       return int'($urandom_range(15));
      default: return int'($urandom_range(2047));
    endcase
  endfunction

  // Sphere placed within reach of the box so that hits and near misses dominate
  function automatic sphere_box_t near_query();
    int sz[3];
    int bc[3];
    int sc[3];
    int r, reach, off;
    r = pick_size();
    for (int i = 0; i < 3; i++) begin
      sz[i] = pick_size();
      bc[i] = int'($urandom_range(65535)) - 32768;
      reach = sz[i] / 2 + r + 2;
      off   = int'($urandom_range(2 * reach)) - reach;
      sc[i] = bc[i] + off;
      if (sc[i] > 32767) sc[i] = 32767;
      if (sc[i] < -32768) sc[i] = -32768;
    end
    return make_query(sc[0], sc[1], sc[2], r, bc[0], bc[1], bc[2], sz[0], sz[1], sz[2]);
  endfunction

  function automatic sphere_box_t noise_query();
    return make_query($urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // Offer one query and hold it until the transfer
  task automatic send_query(input sphere_box_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.sphere_x      <= q.sx;
    in_if.sphere_y      <= q.sy;
    in_if.sphere_z      <= q.sz;
    in_if.sphere_radius <= q.radius;
    in_if.box_x         <= q.bx;
    in_if.box_y         <= q.by;
    in_if.box_z         <= q.bz;
    in_if.extent_x      <= q.ex;
    in_if.extent_y      <= q.ey;
    in_if.extent_z      <= q.ez;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic wait_for_contacts();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_contacts.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(make_query(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767));
    send_query(make_query(-32768, -32768, -32768, 0, -32768, -32768, -32768, 0, 0, 0));
    send_query(make_query(-32768, -32768, -32768, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767));
    send_query(make_query(32767, 0, 0, 32767, -32768, 0, 0, 32767, 0, 0));
    // Two large axis distances, each below the radius, sum still below its square
    send_query(make_query(-12768, -12768, -32768, 32767, -32768, -32768, -32768, 0, 0, 0));
    send_query(make_query(-32768, 32767, -32768, 32767, 32767, -32768, 32767,
                          0, 32767, 0));
  endtask

  task automatic test_faces();
    send_query(make_query(-300, 0, 0, 1024, 0, 0, 0, 512, 512, 512));
    send_query(make_query(300, 0, 0, 1024, 0, 0, 0, 512, 512, 512));
    send_query(make_query(0, -300, 0, 1024, 0, 0, 0, 512, 512, 512));
    send_query(make_query(0, 300, 0, 1024, 0, 0, 0, 512, 512, 512));
    send_query(make_query(0, 0, -300, 1024, 0, 0, 0, 512, 512, 512));
    send_query(make_query(0, 0, 300, 1024, 0, 0, 0, 512, 512, 512));
    // x dominant but z beyond both x and its half size takes over
    send_query(make_query(-300, 0, -400, 1024, 0, 0, 0, 512, 512, 512));
    // x dominant yet within the half size: falls back to y
    send_query(make_query(-100, 0, 0, 1024, 0, 0, 0, 512, 512, 512));
    send_query(make_query(5, 5, 5, 1024, 5, 5, 5, 512, 512, 512));
  endtask

  task automatic test_bounds();
    // Axis distance equal to the radius, then one below it
    send_query(make_query(10, 0, 0, 10, 0, 0, 0, 0, 0, 0));
    send_query(make_query(10, 0, 0, 11, 0, 0, 0, 0, 0, 0));
    // Sum of squares equal to radius squared, then just inside
    send_query(make_query(3, 4, 0, 5, 0, 0, 0, 0, 0, 0));
    send_query(make_query(3, 4, 0, 6, 0, 0, 0, 0, 0, 0));
    // Odd full size: the dropped low bit decides
    send_query(make_query(3, 0, 0, 1, 0, 0, 0, 5, 5, 5));
    send_query(make_query(2, 0, 0, 1, 0, 0, 0, 5, 5, 5));
    send_query(make_query(1, 0, 0, 1, 0, 0, 0, 1, 1, 1));
  endtask

  task automatic test_random(input int count, input int tx_idle, input int rx_idle);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    repeat (count) begin
      if ($urandom_range(9) < 7) send_query(near_query());
      else send_query(noise_query());
    end
  endtask

  // Hold the output off while queries keep coming, then pause until all are back
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_requests++;
    repeat (30) send_query(near_query());
    wait_for_contacts();
  endtask

  always @(posedge clk_i) begin
    if (stall_served != stall_requests) begin
      stall_served = stall_requests;
      stall_left   = STALL_LEN;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    sphere_box_t seen;
    contact_t    want;
    if (rst_ni) begin
      // Push before pop: a transfer in and a result out may share an edge
      if (in_if.valid && in_if.ready) begin
        seen.sx     = in_if.sphere_x;
        seen.sy     = in_if.sphere_y;
        seen.sz     = in_if.sphere_z;
        seen.radius = in_if.sphere_radius;
        seen.bx     = in_if.box_x;
        seen.by     = in_if.box_y;
        seen.bz     = in_if.box_z;
        seen.ex     = in_if.extent_x;
        seen.ey     = in_if.extent_y;
        seen.ez     = in_if.extent_z;
        pending_contacts.push_back(classify_contact(seen));
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_contacts.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result hit=%0b face=%0d", $time,
                     out_if.hit, out_if.hit_face);
        end else begin
          want = pending_contacts.pop_front();
          if (out_if.hit !== want.hit || out_if.hit_face !== want.face) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: result differs: expected hit=%0b face=%0d, got hit=%0b face=%0d",
                       $time, want.hit, want.face, out_if.hit, out_if.hit_face);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.sphere_x      = '0;
    in_if.sphere_y      = '0;
    in_if.sphere_z      = '0;
    in_if.sphere_radius = '0;
    in_if.box_x         = '0;
    in_if.box_y         = '0;
    in_if.box_z         = '0;
    in_if.extent_x      = '0;
    in_if.extent_y      = '0;
    in_if.extent_z      = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_faces();
    test_bounds();
    test_random(170, 33, 64);
    test_output_stall();
    test_random(170, 64, 33);
    test_random(180, 0, 0);

    wait_for_contacts();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_contacts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
